// File: rtl/linear_probe_hash_table_defines.svh
// ----------------------------------------------------------------------------
// linear_probe_hash_table_defines
// Assertion macros for the linear probe hash table.
// LPHT_ASSERT checks a property outside reset; LPHT_ASSERT_ALWAYS checks it
// on every clock edge, reset included.
// ----------------------------------------------------------------------------
`ifndef LINEAR_PROBE_HASH_TABLE_DEFINES_SVH
`define LINEAR_PROBE_HASH_TABLE_DEFINES_SVH

`ifndef SYNTHESIS
`define LPHT_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("lpht: assertion failed");
`define LPHT_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("lpht: assertion failed");
`else
`define LPHT_ASSERT(lbl, clk, rst, prop)
`define LPHT_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// File: rtl/lpht_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared widths, request and status codes and slot tags of the hash table.
// ----------------------------------------------------------------------------
package lpht_pkg;

   localparam int KEY_W      = 32;
   localparam int VAL_W      = 32;
   localparam int REQ_W      = 2;
   localparam int STAT_W     = 2;
   localparam int SLOT_OUT_W = 8;

   localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
   localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd1;
   localparam logic [REQ_W-1:0] REQ_DELETE = 2'd2;
   localparam logic [REQ_W-1:0] REQ_NOP    = 2'd3;

   localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
   localparam logic [STAT_W-1:0] STAT_MISSING = 2'd1;
   localparam logic [STAT_W-1:0] STAT_FULL    = 2'd2;

   typedef enum logic [1:0] {
      TAG_EMPTY = 2'd0,
      TAG_USED  = 2'd1,
      TAG_TOMB  = 2'd2
   } tag_type;

endpackage

// File: rtl/lpht_home.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_home
// Home slot unit: key mod SLOTS by reciprocal multiply, then fold,
// or a plain mask when SLOTS is a power of two.
// ----------------------------------------------------------------------------
module lpht_home
   import lpht_pkg::*;
#(
   parameter int SLOTS = 256
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [KEY_W-1:0]           key,
   output logic                       done,
   output logic [$clog2(SLOTS)-1:0]   home
);

   localparam int IDX_W   = $clog2(SLOTS);
   localparam int MAG_W   = KEY_W + 1;
   localparam int PROD_W  = KEY_W + MAG_W;
   localparam int SHIFT   = KEY_W + IDX_W;
   localparam bit IS_POW2 = ((SLOTS & (SLOTS - 1)) == 0);
   // ceil(2^SHIFT / SLOTS) gives the exact quotient for every key
   localparam logic [63:0] MAGIC_WIDE =
      ((64'd1 << SHIFT) + 64'(SLOTS) - 64'd1) / 64'(SLOTS);
   localparam logic [MAG_W-1:0] MAGIC   = MAGIC_WIDE[MAG_W-1:0];
   localparam logic [IDX_W-1:0] MODULUS = IDX_W'(SLOTS);

   logic                run_ff;
   logic                fold_ff;
   logic                done_ff;
   logic [KEY_W-1:0]    key_ff;
   logic [PROD_W-1:0]   prod_ff;
   logic [IDX_W-1:0]    home_ff;
   logic [IDX_W-1:0]    quo_lo;
   logic [IDX_W-1:0]    qm_lo;

   // remainder is below SLOTS, so the low index bits carry all of it
   assign quo_lo = prod_ff[SHIFT +: IDX_W];
   assign qm_lo  = quo_lo * MODULUS;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         fold_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            if (IS_POW2) begin
               home_ff <= key[IDX_W-1:0];
               done_ff <= 1'b1;
            end else begin
               run_ff <= 1'b1;
               key_ff <= key;
            end
         end else if (run_ff) begin
            prod_ff <= PROD_W'(key_ff) * PROD_W'(MAGIC);
            run_ff  <= 1'b0;
            fold_ff <= 1'b1;
         end else if (fold_ff) begin
            home_ff <= key_ff[IDX_W-1:0] - qm_lo;
            fold_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   assign done = done_ff;
   assign home = home_ff;

endmodule

// File: rtl/linear_probe_hash_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_probe_hash_table
// Open-addressing key/value table with linear probing and tombstones.
// ----------------------------------------------------------------------------
// Usage:
//   Request: drive req_type/req_key/req_value and raise start; the item is
//   taken at a clock edge where start is high and busy is low. Insert (0),
//   lookup (1), delete (2); code 3 is answered as not found at once.
//   Response: one item per request, shown on rsp_* for a single cycle with
//   rsp_valid high. The receiver cannot stall; it must take it then.
//   Walk: the home slot is a plain mask when SLOTS is a power of two and
//   key mod SLOTS by reciprocal multiply otherwise. The probe then reads
//   one slot per cycle from the slot memories, through registered read
//   data in rd_*_ff.
//   A walk covers at most SLOTS slots; rsp_valid comes in the first cycle
//   in which busy is low again, and the next item may be taken in that
//   same cycle.
//   Reset: after reset the tag memory is swept to empty, one slot per
//   cycle, over all SLOTS slots; busy stays high until the sweep ends.
// ----------------------------------------------------------------------------
`include "linear_probe_hash_table_defines.svh"

module linear_probe_hash_table
   import lpht_pkg::*;
#(
   parameter int SLOTS = 256
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [REQ_W-1:0]        req_type,
   input  logic [KEY_W-1:0]        req_key,
   input  logic [VAL_W-1:0]        req_value,
   output logic                    rsp_valid,
   output logic [STAT_W-1:0]       rsp_status,
   output logic [VAL_W-1:0]        rsp_found_value,
   output logic [SLOT_OUT_W-1:0]   rsp_slot_index
);

   localparam int IDX_W  = $clog2(SLOTS);
   localparam int SEEN_W = IDX_W + 1;
   localparam int EXT_W  = IDX_W + SLOT_OUT_W;
   localparam logic [IDX_W-1:0]  LAST_SLOT  = IDX_W'(SLOTS - 1);
   localparam logic [SEEN_W-1:0] LAST_SEEN  = SEEN_W'(SLOTS - 1);
   localparam logic [SEEN_W-1:0] SEEN_LIMIT = SEEN_W'(SLOTS);

   typedef enum logic [1:0] {
      CLEAR,
      IDLE,
      HOME,
      PROBE
   } state_type;

   state_type            state_ff;
   logic [REQ_W-1:0]     op_ff;
   logic [KEY_W-1:0]     key_ff;
   logic [VAL_W-1:0]     val_ff;
   logic [IDX_W-1:0]     clr_ff;
   logic [IDX_W-1:0]     pos_ff;
   logic [IDX_W-1:0]     eval_ff;
   logic                 rd_ok_ff;
   logic [SEEN_W-1:0]    seen_ff;
   logic [IDX_W-1:0]     tomb_ff;
   logic                 have_tomb_ff;
   logic                 rsp_valid_ff;
   logic [STAT_W-1:0]    rsp_status_ff;
   logic [VAL_W-1:0]     rsp_fval_ff;
   logic [SLOT_OUT_W-1:0] rsp_slot_ff;

   // slot memories
   tag_type              tag_mem_ff [SLOTS];
   logic [KEY_W-1:0]     key_mem_ff [SLOTS];
   logic [VAL_W-1:0]     val_mem_ff [SLOTS];
   tag_type              rd_tag_ff;
   logic [KEY_W-1:0]     rd_key_ff;
   logic [VAL_W-1:0]     rd_val_ff;

   logic                 accept;
   logic                 home_start;
   logic                 home_done;
   logic [IDX_W-1:0]     home_slot;
   logic [IDX_W-1:0]     pos_in;
   logic                 last;
   logic                 hit;
   logic                 fin;
   logic [STAT_W-1:0]    fin_status;
   logic [IDX_W-1:0]     fin_slot;
   logic [VAL_W-1:0]     fin_fval;
   logic [EXT_W-1:0]     fin_slot_ext;
   logic                 wr_en;
   logic                 wr_kv;
   logic [IDX_W-1:0]     wr_addr;
   tag_type              wr_tag;

   assign busy       = (state_ff != IDLE);
   assign accept     = start && (state_ff == IDLE);
   assign home_start = accept && (req_type != REQ_NOP);

   lpht_home #(
      .SLOTS (SLOTS)
   ) u_home (
      .clock (clock),
      .reset (reset),
      .start (home_start),
      .key   (req_key),
      .done  (home_done),
      .home  (home_slot)
   );

   assign pos_in = (pos_ff == LAST_SLOT) ? '0 : (pos_ff + IDX_W'(1));
   assign last   = (seen_ff == LAST_SEEN);
   assign hit    = (rd_tag_ff == TAG_USED) && (rd_key_ff == key_ff);

   // probe decision for the slot whose read data is in rd_*_ff
   always_comb begin
      fin        = 1'b0;
      fin_status = STAT_MISSING;
      fin_slot   = '0;
      fin_fval   = '0;
      wr_en      = 1'b0;
      wr_kv      = 1'b0;
      wr_addr    = eval_ff;
      wr_tag     = TAG_USED;
      if (state_ff == CLEAR) begin
         wr_en   = 1'b1;
         wr_addr = clr_ff;
         wr_tag  = TAG_EMPTY;
      end else if ((state_ff == PROBE) && rd_ok_ff) begin
         case (op_ff)
            REQ_INSERT: begin
               if (rd_tag_ff == TAG_EMPTY) begin
                  fin        = 1'b1;
                  fin_status = STAT_OK;
                  fin_slot   = have_tomb_ff ? tomb_ff : eval_ff;
               end else if ((rd_tag_ff != TAG_TOMB) && (rd_key_ff == key_ff)) begin
                  fin        = 1'b1;
                  fin_status = STAT_OK;
                  fin_slot   = eval_ff;
               end else if (last) begin
                  // walk exhausted: fall back to the last tombstone passed
                  fin = 1'b1;
                  if (rd_tag_ff == TAG_TOMB) begin
                     fin_status = STAT_OK;
                     fin_slot   = eval_ff;
                  end else if (have_tomb_ff) begin
                     fin_status = STAT_OK;
                     fin_slot   = tomb_ff;
                  end else begin
                     fin_status = STAT_FULL;
                  end
               end
               wr_en   = fin && (fin_status == STAT_OK);
               wr_kv   = wr_en;
               wr_addr = fin_slot;
               wr_tag  = TAG_USED;
            end
            REQ_LOOKUP, REQ_DELETE: begin
               if (hit) begin
                  fin        = 1'b1;
                  fin_status = STAT_OK;
                  fin_slot   = eval_ff;
                  fin_fval   = (op_ff == REQ_LOOKUP) ? rd_val_ff : '0;
                  wr_en      = (op_ff == REQ_DELETE);
                  wr_tag     = TAG_TOMB;
               end else if ((rd_tag_ff == TAG_EMPTY) || last) begin
                  fin = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign fin_slot_ext = {{SLOT_OUT_W{1'b0}}, fin_slot};

   always_ff @(posedge clock) begin
      if (wr_en) begin
         tag_mem_ff[wr_addr] <= wr_tag;
      end
      if (wr_kv) begin
         key_mem_ff[wr_addr] <= key_ff;
         val_mem_ff[wr_addr] <= val_ff;
      end
      rd_tag_ff <= tag_mem_ff[pos_ff];
      rd_key_ff <= key_mem_ff[pos_ff];
      rd_val_ff <= val_mem_ff[pos_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            CLEAR: begin
               clr_ff <= clr_ff + IDX_W'(1);
               if (clr_ff == LAST_SLOT) begin
                  state_ff <= IDLE;
               end
            end
            IDLE: begin
               if (start) begin
                  op_ff  <= req_type;
                  key_ff <= req_key;
                  val_ff <= req_value;
                  if (req_type == REQ_NOP) begin
                     rsp_valid_ff  <= 1'b1;
                     rsp_status_ff <= STAT_MISSING;
                     rsp_fval_ff   <= '0;
                     rsp_slot_ff   <= '0;
                  end else begin
                     state_ff <= HOME;
                  end
               end
            end
            HOME: begin
               if (home_done) begin
                  pos_ff       <= home_slot;
                  rd_ok_ff     <= 1'b0;
                  seen_ff      <= '0;
                  have_tomb_ff <= 1'b0;
                  state_ff     <= PROBE;
               end
            end
            PROBE: begin
               // read of pos_ff is issued while eval_ff is decided
               pos_ff   <= pos_in;
               eval_ff  <= pos_ff;
               rd_ok_ff <= 1'b1;
               if (rd_ok_ff) begin
                  seen_ff <= seen_ff + SEEN_W'(1);
                  if ((op_ff == REQ_INSERT) && (rd_tag_ff == TAG_TOMB)) begin
                     tomb_ff      <= eval_ff;
                     have_tomb_ff <= 1'b1;
                  end
               end
               if (fin) begin
                  state_ff      <= IDLE;
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= fin_status;
                  rsp_fval_ff   <= fin_fval;
                  rsp_slot_ff   <= fin_slot_ext[SLOT_OUT_W-1:0];
               end
            end
            default: begin
               state_ff <= CLEAR;
               clr_ff   <= '0;
            end
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_found_value = rsp_fval_ff;
   assign rsp_slot_index  = rsp_slot_ff;

   `LPHT_ASSERT_ALWAYS(a_reset_sweeps, clock, reset |=> (!rsp_valid && busy))
   `LPHT_ASSERT(a_rsp_when_idle, clock, reset, rsp_valid_ff |-> !busy)
   `LPHT_ASSERT(a_accept_moves, clock, reset, accept |=> (rsp_valid_ff || busy))
   `LPHT_ASSERT(a_full_on_insert, clock, reset, (rsp_valid_ff && (rsp_status_ff == STAT_FULL)) |-> (op_ff == REQ_INSERT))
   `LPHT_ASSERT(a_walk_bound, clock, reset, (state_ff == PROBE) |-> (seen_ff < SEEN_LIMIT))

endmodule
